FILE: src/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package pva_pkg;

   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned HIT_CNT_W   = 5;   // holds 0 .. MAX_RESULTS
   localparam int unsigned STAMP_W     = 64;
   localparam int unsigned NOTE_W      = 7;

   typedef enum logic [1:0] {
      ACT_NOTE_ON       = 2'd0,
      ACT_NOTE_OFF      = 2'd1,
      ACT_ALL_NOTES_OFF = 2'd2,
      ACT_VOICE_DONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_START      = 2'd0,
      CMD_KILL_START = 2'd1,
      CMD_RELEASE    = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_COMMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [6:0]  note;
      logic [7:0]  velocity;
      logic [3:0]  done_voice;
   } req_type;

   typedef struct packed {
      logic [3:0]  voice;
      command_type command;
      logic [6:0]  voice_note;
      logic [7:0]  voice_velocity;
      logic [6:0]  glide_from_note;
      logic        glide_from_valid;
      logic        last;
   } rsp_type;

   // one entry of the voice memory
   typedef struct packed {
      logic [NOTE_W-1:0]  note;
      logic [STAMP_W-1:0] stamp;
   } voice_entry_type;

   // control from the scan sequencer to the steal picker
   typedef struct packed {
      logic clear;      // start of a new search
      logic check;      // one entry presented this cycle
      logic match;      // entry already plays the requested note
      logic releasing;  // entry is in its release phase
   } pick_step_type;

endpackage

`default_nettype wire

FILE: src/pva_pick.sv
// Steal picker: tracks the best victim voice while entries stream past.
// Depends on pva_pkg.
`default_nettype none

module pva_pick #(
   parameter int unsigned IDX_W = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pva_pkg::pick_step_type       step,
   input  wire logic [IDX_W-1:0]             step_idx,
   input  wire logic [pva_pkg::STAMP_W-1:0]  step_stamp,
   output logic      [IDX_W-1:0]             pick_idx
);
   import pva_pkg::*;

   logic               match_found_ff, match_found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic               rel_found_ff, rel_found_in;
   logic [IDX_W-1:0]   rel_idx_ff, rel_idx_in;
   logic [STAMP_W-1:0] rel_stamp_ff, rel_stamp_in;
   logic               old_found_ff, old_found_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [STAMP_W-1:0] old_stamp_ff, old_stamp_in;

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      rel_found_in   = rel_found_ff;
      rel_idx_in     = rel_idx_ff;
      rel_stamp_in   = rel_stamp_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      old_stamp_in   = old_stamp_ff;
      if (step.clear) begin
         match_found_in = 1'b0;
         rel_found_in   = 1'b0;
         old_found_in   = 1'b0;
      end else if (step.check) begin
         // first entry on the same note wins
         if (step.match && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = step_idx;
         end
         // strict less-than keeps the lowest index on equal stamps
         if (step.releasing && (!rel_found_ff || step_stamp < rel_stamp_ff)) begin
            rel_found_in = 1'b1;
            rel_idx_in   = step_idx;
            rel_stamp_in = step_stamp;
         end
         if (!old_found_ff || step_stamp < old_stamp_ff) begin
            old_found_in = 1'b1;
            old_idx_in   = step_idx;
            old_stamp_in = step_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         rel_found_ff   <= 1'b0;
         old_found_ff   <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         rel_found_ff   <= rel_found_in;
         old_found_ff   <= old_found_in;
      end
      match_idx_ff <= match_idx_in;
      rel_idx_ff   <= rel_idx_in;
      rel_stamp_ff <= rel_stamp_in;
      old_idx_ff   <= old_idx_in;
      old_stamp_ff <= old_stamp_in;
   end

   always_comb begin
      if (match_found_ff) begin
         pick_idx = match_idx_ff;
      end else if (rel_found_ff) begin
         pick_idx = rel_idx_ff;
      end else begin
         pick_idx = old_idx_ff;
      end
   end

endmodule

`default_nettype wire

FILE: src/polyphonic_voice_allocator.sv
// Polyphonic voice allocator with voice stealing: top level.
// Depends on pva_pkg and pva_pick.
//
//  channel   ports                          handshake
//  --------  -----------------------------  -------------------------------
//  request   start, busy, req_data          taken when start && !busy
//  response  rsp_valid, rsp_data            one-cycle strobe, never stalled
//
// Flow: a note_on with an idle voice passes DISPATCH and COMMIT, then
// returns to idle. Any other note_on, note_off or all_notes_off walks the
// voice memory one entry a cycle through its single read port, then goes
// to COMMIT or FLUSH. voice_finished is done in DISPATCH alone.
// Reset clears the control state and the active/releasing bits at once;
// the note/stamp memory needs no clearing pass, as its data is only used
// for voices that a note_on has written. Results cannot be stalled, so they
// leave on a strobe, at most one per cycle, in voice order.
`default_nettype none

module polyphonic_voice_allocator #(
   parameter int unsigned VOICES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pva_pkg::req_type req_data,
   output logic                  rsp_valid,
   output pva_pkg::rsp_type      rsp_data
);
   import pva_pkg::*;

   localparam int unsigned IDX_W = $clog2(VOICES);
   localparam int unsigned CNT_W = IDX_W + 1;   // scan counter reaches VOICES
   localparam int unsigned EXT_W = IDX_W + 4;   // room for a 4-bit index too
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [VOICES-1:0]     act_ff, act_in;      // voice sounding
   logic [VOICES-1:0]     rel_ff, rel_in;      // voice in release
   logic [STAMP_W-1:0]    cnt_ff, cnt_in;      // note_on tick counter
   logic [NOTE_W-1:0]     prev_note_ff, prev_note_in;
   logic                  prev_vld_ff, prev_vld_in;

   // scan pipeline: address stage, then check stage on the read data
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;

   // selected voice for the note_on commit
   logic [IDX_W-1:0]      sel_idx_ff, sel_idx_in;
   logic                  sel_kill_ff, sel_kill_in;

   // one release held back so the final one can carry last
   logic                  pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [NOTE_W-1:0]     pend_note_ff, pend_note_in;
   logic [HIT_CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------
   // Voice memory: note and start stamp per voice
   // ---------------------------------------------------------------
   voice_entry_type       mem [VOICES];
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   voice_entry_type       rd_data_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   voice_entry_type       wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------
   // Steal picker
   // ---------------------------------------------------------------
   pick_step_type         pick_step;
   logic [IDX_W-1:0]      pick_idx;

   pva_pick #(
      .IDX_W (IDX_W)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .step       (pick_step),
      .step_idx   (chk_idx_ff),
      .step_stamp (rd_data_ff.stamp),
      .pick_idx   (pick_idx)
   );

   // ---------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------
   logic                  any_free;
   logic [IDX_W-1:0]      free_idx;
   logic [EXT_W-1:0]      dv_ext;
   logic                  dv_ok;
   logic                  chk_act, chk_rel, chk_note_eq, chk_hit;
   logic [EXT_W-1:0]      pend_ext, sel_ext;
   logic [STAMP_W-1:0]    cnt_next;
   logic [IDX_W-1:0]      commit_idx;

   // lowest idle voice
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // picker result is registered on its last check, so it is ready in COMMIT
   assign commit_idx  = sel_kill_ff ? pick_idx : sel_idx_ff;

   assign dv_ext      = EXT_W'(req_ff.done_voice);
   assign dv_ok       = dv_ext < EXT_W'(VOICES);
   assign chk_act     = act_ff[chk_idx_ff];
   assign chk_rel     = rel_ff[chk_idx_ff];
   assign chk_note_eq = rd_data_ff.note == req_ff.note;
   assign pend_ext    = EXT_W'(pend_idx_ff);
   assign sel_ext     = EXT_W'(commit_idx);
   assign cnt_next    = cnt_ff + STAMP_W'(1);

   // release hit on the entry in the check stage
   always_comb begin
      if (req_ff.action == ACT_NOTE_OFF) begin
         chk_hit = chk_act && !chk_rel && chk_note_eq;
      end else begin
         chk_hit = chk_act;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      act_in       = act_ff;
      rel_in       = rel_ff;
      cnt_in       = cnt_ff;
      prev_note_in = prev_note_ff;
      prev_vld_in  = prev_vld_ff;
      rd_idx_in    = rd_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      sel_idx_in   = sel_idx_ff;
      sel_kill_in  = sel_kill_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      pend_note_in = pend_note_ff;
      hit_cnt_in   = hit_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = commit_idx;
      wr_data.note  = req_ff.note;
      wr_data.stamp = cnt_next;
      pick_step    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            rd_idx_in   = '0;
            pend_vld_in = 1'b0;
            hit_cnt_in  = '0;
            case (req_ff.action)
               ACT_NOTE_ON: begin
                  if (any_free) begin
                     sel_idx_in  = free_idx;
                     sel_kill_in = 1'b0;
                     state_in    = ST_COMMIT;
                  end else begin
                     pick_step.clear = 1'b1;
                     state_in        = ST_SCAN;
                  end
               end
               ACT_NOTE_OFF, ACT_ALL_NOTES_OFF: begin
                  state_in = ST_SCAN;
               end
               default: begin   // voice finished
                  if (dv_ok) begin
                     act_in[dv_ext[IDX_W-1:0]] = 1'b0;
                     rel_in[dv_ext[IDX_W-1:0]] = 1'b0;
                  end
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SCAN: begin
            // address stage
            if (rd_idx_ff < CNT_W'(VOICES)) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end
            // check stage
            if (chk_vld_ff) begin
               if (req_ff.action == ACT_NOTE_ON) begin
                  pick_step.check     = 1'b1;
                  pick_step.match     = chk_note_eq;
                  pick_step.releasing = chk_rel;
               end else if (chk_hit) begin
                  rel_in[chk_idx_ff] = 1'b1;
                  if (hit_cnt_ff < HIT_CNT_W'(MAX_RESULTS)) begin
                     hit_cnt_in = hit_cnt_ff + HIT_CNT_W'(1);
                     if (pend_vld_ff) begin
                        rsp_valid_in                 = 1'b1;
                        rsp_data_in.voice            = pend_ext[3:0];
                        rsp_data_in.command          = CMD_RELEASE;
                        rsp_data_in.voice_note       = pend_note_ff;
                        rsp_data_in.voice_velocity   = '0;
                        rsp_data_in.glide_from_note  = '0;
                        rsp_data_in.glide_from_valid = 1'b0;
                        rsp_data_in.last             = 1'b0;
                     end
                     pend_vld_in  = 1'b1;
                     pend_idx_in  = chk_idx_ff;
                     pend_note_in = rd_data_ff.note;
                  end
               end
               if (chk_idx_ff == LAST_IDX) begin
                  if (req_ff.action == ACT_NOTE_ON) begin
                     state_in = ST_COMMIT;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end

         ST_COMMIT: begin
            // scan path: all voices were active, so the picker result is a kill
            wr_en                        = 1'b1;
            cnt_in                       = cnt_next;
            act_in[commit_idx]           = 1'b1;
            rel_in[commit_idx]           = 1'b0;
            prev_note_in                 = req_ff.note;
            prev_vld_in                  = 1'b1;
            rsp_valid_in                 = 1'b1;
            rsp_data_in.voice            = sel_ext[3:0];
            rsp_data_in.command          = sel_kill_ff ? CMD_KILL_START : CMD_START;
            rsp_data_in.voice_note       = req_ff.note;
            rsp_data_in.voice_velocity   = req_ff.velocity;
            rsp_data_in.glide_from_note  = prev_note_ff;
            rsp_data_in.glide_from_valid = prev_vld_ff;
            rsp_data_in.last             = 1'b1;
            state_in                     = ST_IDLE;
         end

         ST_FLUSH: begin
            if (pend_vld_ff) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.voice            = pend_ext[3:0];
               rsp_data_in.command          = CMD_RELEASE;
               rsp_data_in.voice_note       = pend_note_ff;
               rsp_data_in.voice_velocity   = '0;
               rsp_data_in.glide_from_note  = '0;
               rsp_data_in.glide_from_valid = 1'b0;
               rsp_data_in.last             = 1'b1;
            end
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // scan end on a note_on: take the picker's victim
      if (state_ff == ST_SCAN && chk_vld_ff && chk_idx_ff == LAST_IDX &&
          req_ff.action == ACT_NOTE_ON) begin
         sel_kill_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_ff       <= '0;
         rel_ff       <= '0;
         cnt_ff       <= '0;
         prev_note_ff <= '0;
         prev_vld_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         sel_kill_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         hit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         rel_ff       <= rel_in;
         cnt_ff       <= cnt_in;
         prev_note_ff <= prev_note_in;
         prev_vld_ff  <= prev_vld_in;
         chk_vld_ff   <= chk_vld_in;
         sel_kill_ff  <= sel_kill_in;
         pend_vld_ff  <= pend_vld_in;
         hit_cnt_ff   <= hit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_idx_ff    <= rd_idx_in;
      end
      req_ff       <= req_in;
      chk_idx_ff   <= chk_idx_in;
      sel_idx_ff   <= sel_idx_in;
      pend_idx_ff  <= pend_idx_in;
      pend_note_ff <= pend_note_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff != ST_IDLE))
      else $error("response without a transaction in flight");

   a_hit_cap: assert property (@(posedge clock) disable iff (reset)
      hit_cnt_ff <= HIT_CNT_W'(MAX_RESULTS))
      else $error("release count beyond result cap");

   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_FLUSH))
      else $error("held release outside a scan");

   a_kill_only_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> (sel_kill_ff == act_ff[commit_idx]))
      else $error("start command disagrees with voice activity");

endmodule

`default_nettype wire

FILE: tb/polyphonic_voice_allocator_tb.sv
// Self-checking testbench for the polyphonic voice allocator: directed and random note
// events, each voice command compared field by field with a local allocation model.
// Depends on pva_pkg and the polyphonic_voice_allocator RTL.

module polyphonic_voice_allocator_tb;
   import pva_pkg::*;

   localparam int unsigned VOICES      = 16;
   localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transaction at all
   localparam int unsigned TAIL_CYCLES = VOICES + 8;

   // all inputs known from time zero; reset held high until the sequence drops it
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   polyphonic_voice_allocator #(
      .VOICES (VOICES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Allocation model: mirror of the voice pool, updated on every
   // accepted request transaction.
   // ------------------------------------------------------------------
   logic        voice_on    [VOICES];
   logic        voice_rel   [VOICES];
   logic [6:0]  voice_pitch [VOICES];
   logic [63:0] voice_age   [VOICES];
   logic [63:0] tick_count;
   logic [6:0]  last_note;
   logic        last_valid;

   rsp_type     pending_cmds[$];     // voice commands still owed by the DUT

   int unsigned mismatches   = 0;
   int unsigned events_sent  = 0;
   int unsigned cmds_checked = 0;
   int unsigned steals       = 0;
   int unsigned releases     = 0;
   logic [6:0]  note_base    = 7'd40; // base of the note pool for random traffic

   initial begin
      for (int i = 0; i < VOICES; i++) begin
         voice_on[i]    = 1'b0;
         voice_rel[i]   = 1'b0;
         voice_pitch[i] = '0;
         voice_age[i]   = '0;
      end
      tick_count = '0;
      last_note  = '0;
      last_valid = 1'b0;
   end

   // Works out the commands one event causes and queues them.
   task automatic allocate_voices(input req_type ev);
      int unsigned pick;
      rsp_type     cmd;
      rsp_type     batch[$];
      int unsigned n;
      logic        hit;
      n = 0;
      case (ev.action)
         ACT_NOTE_ON: begin
            // search order: idle, same note, oldest releasing, oldest overall
            pick = VOICES;
            for (int i = 0; i < VOICES; i++)
               if (!voice_on[i] && pick == VOICES) pick = i;
            if (pick == VOICES)
               for (int i = 0; i < VOICES; i++)
                  if (voice_pitch[i] == ev.note && pick == VOICES) pick = i;
            if (pick == VOICES)
               for (int i = 0; i < VOICES; i++)
                  if (voice_rel[i] && (pick == VOICES || voice_age[i] < voice_age[pick]))
                     pick = i;
            if (pick == VOICES) begin
               pick = 0;
               for (int i = 1; i < VOICES; i++)
                  if (voice_age[i] < voice_age[pick]) pick = i;
            end
            cmd.voice            = pick[3:0];
            cmd.command          = voice_on[pick] ? CMD_KILL_START : CMD_START;
            cmd.voice_note       = ev.note;
            cmd.voice_velocity   = ev.velocity;
            cmd.glide_from_note  = last_note;
            cmd.glide_from_valid = last_valid;
            cmd.last             = 1'b1;
            if (voice_on[pick]) steals++;
            batch.push_back(cmd);
            tick_count        = tick_count + 64'd1;
            voice_on[pick]    = 1'b1;
            voice_rel[pick]   = 1'b0;
            voice_pitch[pick] = ev.note;
            voice_age[pick]   = tick_count;
            last_note         = ev.note;
            last_valid        = 1'b1;
         end
         ACT_NOTE_OFF, ACT_ALL_NOTES_OFF: begin
            // note_off skips voices already releasing; all_notes_off does not
            for (int i = 0; i < VOICES; i++) begin
               hit = voice_on[i] && (ev.action == ACT_ALL_NOTES_OFF ||
                                     (!voice_rel[i] && voice_pitch[i] == ev.note));
               if (hit) begin
                  voice_rel[i] = 1'b1;
                  if (n < MAX_RESULTS) begin
                     cmd.voice            = 4'(i);
                     cmd.command          = CMD_RELEASE;
                     cmd.voice_note       = voice_pitch[i];
                     cmd.voice_velocity   = '0;
                     cmd.glide_from_note  = '0;
                     cmd.glide_from_valid = 1'b0;
                     cmd.last             = 1'b0;
                     batch.push_back(cmd);
                     n++;
                  end
               end
            end
            if (n > 0) batch[n-1].last = 1'b1;
            releases += n;
         end
         default: begin
            // envelope finished: the voice goes idle, note and stamp kept
            if (ev.done_voice < VOICES) begin
               voice_on[ev.done_voice]  = 1'b0;
               voice_rel[ev.done_voice] = 1'b0;
            end
         end
      endcase
      foreach (batch[k]) pending_cmds.push_back(batch[k]);
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   function automatic req_type make_event(action_type act, int unsigned pitch,
                                          int unsigned vel, int unsigned dv);
      req_type ev;
      ev.action     = act;
      ev.note       = 7'(pitch);
      ev.velocity   = 8'(vel);
      ev.done_voice = 4'(dv);
      return ev;
   endfunction

   // Holds start high until the transaction is taken and the allocator is idle again,
   // then updates the model; start is left high between back-to-back transactions.
   task automatic send_event(input req_type ev);
      start    <= 1'b1;
      req_data <= ev;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      allocate_voices(ev);
      events_sent++;
   endtask

   task automatic idle_gap(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender holds off until every owed command is out, plus the scan time
   // for a trailing event that owes nothing.
   task automatic test_drain_pause();
      start <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Mostly note traffic on a narrow pool so note_offs find their voices;
   // one in five notes comes from the full range.
   function automatic req_type random_event();
      req_type     ev;
      int unsigned roll;
      ev.velocity   = 8'($urandom);
      ev.done_voice = 4'($urandom);
      if ($urandom_range(0, 4) == 0) ev.note = 7'($urandom);
      else ev.note = note_base + 7'($urandom_range(0, 11));
      roll = $urandom_range(0, 99);
      if (roll < 45) ev.action = ACT_NOTE_ON;
      else if (roll < 70) ev.action = ACT_NOTE_OFF;
      else if (roll < 74) ev.action = ACT_ALL_NOTES_OFF;
      else ev.action = ACT_VOICE_DONE;
      return ev;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // First note has no glide source; note_off with no match and a repeated
   // note_off give nothing; all_notes_off also hits releasing voices.
   task automatic test_single_voice_events();
      send_event(make_event(ACT_NOTE_ON, 0, 0, 0));
      send_event(make_event(ACT_NOTE_ON, 127, 255, 15));
      send_event(make_event(ACT_NOTE_OFF, 99, 0, 0));
      send_event(make_event(ACT_NOTE_OFF, 127, 0, 0));
      send_event(make_event(ACT_NOTE_OFF, 127, 0, 0));
      send_event(make_event(ACT_ALL_NOTES_OFF, 0, 0, 0));
      send_event(make_event(ACT_VOICE_DONE, 0, 0, 0));
      send_event(make_event(ACT_VOICE_DONE, 0, 0, 1));
      send_event(make_event(ACT_ALL_NOTES_OFF, 0, 0, 0));   // nothing active
   endtask

   // Fills the pool, then walks every steal rule and the widest release burst.
   task automatic test_voice_stealing();
      for (int i = 0; i < VOICES; i++)
         send_event(make_event(ACT_NOTE_ON, 40 + i, i * 17, 0));
      send_event(make_event(ACT_NOTE_ON, 45, 200, 0));      // same note reused
      send_event(make_event(ACT_NOTE_ON, 100, 77, 0));      // oldest voice overall
      send_event(make_event(ACT_NOTE_OFF, 42, 0, 0));
      send_event(make_event(ACT_NOTE_OFF, 47, 0, 0));
      send_event(make_event(ACT_NOTE_ON, 101, 33, 0));      // oldest releasing voice
      send_event(make_event(ACT_ALL_NOTES_OFF, 0, 0, 0));   // all sixteen release
      send_event(make_event(ACT_NOTE_ON, 102, 128, 0));
   endtask

   // Random traffic in blocks of 20; each block is either gap-free or gets
   // idle gaps of random length, when gaps are allowed at all.
   task automatic test_random_traffic(input int unsigned count, input bit gaps);
      bit gappy;
      gappy = 1'b0;
      for (int unsigned k = 0; k < count; k++) begin
         if (k % 20 == 0) begin
            gappy     = gaps && ($urandom_range(0, 2) != 0);
            note_base = 7'($urandom_range(0, 116));
         end
         if (gappy && $urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 17));
         send_event(random_event());
      end
   endtask

   // ------------------------------------------------------------------
   // Response checking: results cannot be held off, so every strobe is
   // taken at the edge that ends its cycle and compared with the oldest
   // owed command.
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command on voice %0d", rsp_data.voice));
         end else begin
            want = pending_cmds.pop_front();
            cmds_checked++;
            compare_field("strobe", 8'(rsp_valid), 8'd1);
            compare_field("voice", 8'(rsp_data.voice), 8'(want.voice));
            compare_field("command", 8'(rsp_data.command), 8'(want.command));
            compare_field("voice_note", 8'(rsp_data.voice_note), 8'(want.voice_note));
            compare_field("voice_velocity", rsp_data.voice_velocity, want.voice_velocity);
            compare_field("glide_from_note", 8'(rsp_data.glide_from_note),
                          8'(want.glide_from_note));
            compare_field("glide_from_valid", 8'(rsp_data.glide_from_valid),
                          8'(want.glide_from_valid));
            compare_field("last", 8'(rsp_data.last), 8'(want.last));
         end
      end
   end

   // Watchdog: any taken request or any result strobe restarts the count.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_voice_events();
      test_voice_stealing();
      test_random_traffic(80, 1'b1);
      test_drain_pause();
      test_random_traffic(60, 1'b1);
      test_drain_pause();
      // closing stretch runs back to back
      test_random_traffic(40, 1'b0);

      start <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_cmds.size() != 0)
         report_mismatch($sformatf("%0d commands never arrived", pending_cmds.size()));

      $display("Sent %0d note events; checked %0d voice commands.", events_sent, cmds_checked);
      $display("Saw %0d voice steals and %0d releases; %0d mismatches.",
               steals, releases, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/pva_pkg.sv
src/pva_pick.sv
src/polyphonic_voice_allocator.sv
tb/polyphonic_voice_allocator_tb.sv
